@@ rtl/rcvf_pkg.sv @@
// Shared types and constants for the range cluster vote filter.
// Used by rcvf_match, rcvf_div and the top level range_cluster_vote_filter.
package rcvf_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int AVG_W            = 20;
    localparam int VOTES_W          = 6;
    localparam int CLUST_W          = 2;
    localparam int NUM_CLUST        = 3;
    localparam int SUM_W            = 21;
    localparam int FRAC_W           = 4;
    localparam int DIVIDEND_W       = SUM_W + FRAC_W;
    localparam int DIV_STEPS        = DIVIDEND_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
    localparam int COUNT_W          = 6;
    localparam int NUM_READINGS_DEF = 10;

    localparam logic [SAMPLE_W-1:0] ERROR_BOUND_RST = SAMPLE_W'(10);
    localparam logic [CLUST_W-1:0]  LAST_CLUST      = CLUST_W'(NUM_CLUST - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [VOTES_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/range_cluster_vote_filter.sv @@
// Range cluster vote filter, top level: sequencer, cluster state, output word.
// Depends on rcvf_pkg, rcvf_match and rcvf_div.
//
// A sample word is taken when start is high and busy is low. Zero samples are
// taken and ignored. A nonzero sample is compared against the open clusters
// one per cycle on a single shared compare unit, so it keeps busy high until
// its compare is done. The sample that completes a burst of P_NUM_READINGS
// valid samples also picks the winning cluster and runs the serial divider,
// one quotient bit per cycle, after which the quotient is registered: that
// sample keeps busy high until the result word is out. The result word
// appears on the output ports, marked by o_strobe for exactly one cycle;
// the receiver cannot stall it, so it must take the word in that cycle. Busy
// falls in the same cycle the strobe rises, and the cluster state is already
// cleared for the next burst. The error bound register may be written through
// the configuration channel whenever busy is low; its ready follows that same
// condition.
module range_cluster_vote_filter
    import rcvf_pkg::*;
#(
    parameter int P_NUM_READINGS = NUM_READINGS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SAMPLE_W-1:0] i_cfg_data,
    output logic                o_strobe,
    output logic [AVG_W-1:0]    o_average_distance,
    output logic [VOTES_W-1:0]  o_winning_votes,
    output logic [CLUST_W-1:0]  o_winning_cluster
);

    t_state r_state;
    t_state n_state;

    logic [SAMPLE_W-1:0] r_bound;
    logic [SAMPLE_W-1:0] r_sample;
    logic [CLUST_W-1:0]  r_k;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic [NUM_CLUST-1:0] r_open;
    logic [SAMPLE_W-1:0] r_rep   [NUM_CLUST];
    logic [SUM_W-1:0]    r_sum   [NUM_CLUST];
    logic [VOTES_W-1:0]  r_votes [NUM_CLUST];
    logic [CLUST_W-1:0]  r_win;
    logic [VOTES_W-1:0]  r_win_votes;
    logic [AVG_W-1:0]    r_avg;
    logic                r_strobe;

    // Sequencer controls.
    logic do_accept;
    logic do_open;
    logic do_join;
    logic do_adv;
    logic do_match_done;
    logic do_pick;
    logic do_finish;
    logic cfg_wr;

    // Shared compare and read port.
    logic                w_hit;
    logic [CLUST_W-1:0]  w_rd_addr;
    logic [SUM_W-1:0]    w_rd_sum;
    logic [VOTES_W-1:0]  w_rd_votes;
    logic [VOTES_W-1:0]  w_v0;
    logic [VOTES_W-1:0]  w_v1;
    logic [VOTES_W-1:0]  w_v2;
    logic [CLUST_W-1:0]  w_win;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign n_count     = r_count + 1'b1;

    // The one compare unit walks the clusters in order, lowest index first.
    rcvf_match u_match (
        .i_sample (r_sample),
        .i_rep    (r_rep[r_k]),
        .i_bound  (r_bound),
        .o_hit    (w_hit)
    );

    // Clusters that were never opened count as zero votes, so they cannot win.
    assign w_v0 = r_open[0] ? r_votes[0] : '0;
    assign w_v1 = r_open[1] ? r_votes[1] : '0;
    assign w_v2 = r_open[2] ? r_votes[2] : '0;

    // Ties go to the higher cluster number.
    always_comb begin
        if ((w_v2 >= w_v1) && (w_v2 >= w_v0)) begin
            w_win = CLUST_W'(2);
        end else if ((w_v1 >= w_v0) && (w_v1 >= w_v2)) begin
            w_win = CLUST_W'(1);
        end else begin
            w_win = CLUST_W'(0);
        end
    end

    // A single read port on the sum and vote registers: the cluster under test
    // while matching, the winner while picking.
    assign w_rd_addr  = (r_state == ST_PICK) ? w_win : r_k;
    assign w_rd_sum   = r_sum[w_rd_addr];
    assign w_rd_votes = r_votes[w_rd_addr];

    assign w_div_req.start    = do_pick;
    assign w_div_req.dividend = {w_rd_sum, FRAC_W'(0)};
    assign w_div_req.divisor  = w_rd_votes;

    rcvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        do_accept     = 1'b0;
        do_open       = 1'b0;
        do_join       = 1'b0;
        do_adv        = 1'b0;
        do_match_done = 1'b0;
        do_pick       = 1'b0;
        do_finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // A zero sample is taken but leaves everything as it was.
                if (start && (i_sample != '0)) begin
                    do_accept = 1'b1;
                    n_state   = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (!r_open[r_k]) begin
                    do_open       = 1'b1;
                    do_match_done = 1'b1;
                end else if (w_hit) begin
                    do_join       = 1'b1;
                    do_match_done = 1'b1;
                end else if (r_k == LAST_CLUST) begin
                    // All clusters open and none matched: the sample is dropped
                    // but still counts toward the burst.
                    do_match_done = 1'b1;
                end else begin
                    do_adv = 1'b1;
                end
                if (do_match_done) begin
                    if (n_count >= COUNT_W'(P_NUM_READINGS)) begin
                        n_state = ST_PICK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PICK: begin
                do_pick = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    do_finish = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound  <= ERROR_BOUND_RST;
            r_open   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (cfg_wr) begin
                r_bound <= i_cfg_data;
            end
            if (do_finish) begin
                r_open   <= '0;
                r_count  <= '0;
                r_strobe <= 1'b1;
            end else begin
                if (do_open) begin
                    r_open[r_k] <= 1'b1;
                end
                if (do_match_done) begin
                    r_count <= n_count;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (do_accept) begin
            r_sample <= i_sample;
            r_k      <= '0;
        end else if (do_adv) begin
            r_k <= r_k + 1'b1;
        end
        if (do_open) begin
            r_rep[r_k]   <= r_sample;
            r_sum[r_k]   <= SUM_W'(r_sample);
            r_votes[r_k] <= VOTES_W'(1);
        end else if (do_join) begin
            r_sum[r_k]   <= w_rd_sum + SUM_W'(r_sample);
            r_votes[r_k] <= w_rd_votes + 1'b1;
        end
        if (do_pick) begin
            r_win       <= w_win;
            r_win_votes <= w_rd_votes;
        end
        if (do_finish) begin
            r_avg <= (r_win_votes == '0) ? '0 : w_div_rsp.quotient[AVG_W-1:0];
        end
    end

    assign o_strobe           = r_strobe;
    assign o_average_distance = r_avg;
    assign o_winning_votes    = r_win_votes;
    assign o_winning_cluster  = r_win;

endmodule

@@ rtl/rcvf_match.sv @@
// Shared distance compare unit: is a sample within the error bound of a
// representative. Depends on rcvf_pkg.
module rcvf_match
    import rcvf_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_rep,
    input  logic [SAMPLE_W-1:0] i_bound,
    output logic                o_hit
);

    logic [SAMPLE_W-1:0] w_diff;

    // Absolute difference; the bound test is inclusive.
    assign w_diff = (i_sample >= i_rep) ? (i_sample - i_rep) : (i_rep - i_sample);
    assign o_hit  = (w_diff <= i_bound);

endmodule

@@ rtl/rcvf_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on rcvf_pkg for widths and the request and response structs.
module rcvf_div
    import rcvf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [VOTES_W-1:0]    r_rem;
    logic [VOTES_W-1:0]    r_div;
    logic [VOTES_W:0]      w_trial;
    logic                  w_fit;

    assign w_trial = {r_rem, r_q[DIVIDEND_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_fit) begin
                r_rem <= VOTES_W'(w_trial - {1'b0, r_div});
                r_q   <= {r_q[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[VOTES_W-1:0];
                r_q   <= {r_q[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

@@ tb/tb_range_cluster_vote_filter.sv @@
// Self-checking testbench for range_cluster_vote_filter: directed table, then random bursts.
// Depends on rcvf_pkg and the range_cluster_vote_filter RTL, which also needs rcvf_match and rcvf_div.
`timescale 1ns / 1ps

module tb_range_cluster_vote_filter;
    import rcvf_pkg::*;

    // Burst length used for the instance and for the predictor.
    localparam int BURST_LEN   = NUM_READINGS_DEF;
    // Idle cycles allowed after the last owed word before the block counts as idle.
    localparam int SETTLE      = 40;
    // Longest run of cycles in which nothing is taken before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Cap on the sender's gap before one sample word.
    localparam int MAX_GAP     = 24;
    // Count of random sample words, zeros included.
    localparam int RAND_ITEMS  = 1350;
    localparam int NUM_ROWS    = 24;

    localparam logic [CLUST_W-1:0] CL_FIRST  = CLUST_W'(0);
    localparam logic [CLUST_W-1:0] CL_SECOND = CLUST_W'(1);
    localparam logic [CLUST_W-1:0] CL_THIRD  = CLUST_W'(2);

    typedef struct packed {
        logic [AVG_W-1:0]   avg;
        logic [VOTES_W-1:0] votes;
        logic [CLUST_W-1:0] cluster;
    } t_vote_word;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_BOUND
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        t_vote_word          want;
    } t_stim_row;

    localparam t_vote_word NO_WORD = '0;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [SAMPLE_W-1:0] i_sample    = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SAMPLE_W-1:0] i_cfg_data  = '0;
    logic                o_strobe;
    logic [AVG_W-1:0]    o_average_distance;
    logic [VOTES_W-1:0]  o_winning_votes;
    logic [CLUST_W-1:0]  o_winning_cluster;

    // A directed row may carry a hand-written result word. The driver moves
    // these along with start, so the monitor sees them for the sample it takes.
    logic       typed_hold = 1'b0;
    t_vote_word typed_want = '0;

    // Result words the block still owes, oldest first.
    t_vote_word owed_words[$];
    int         mismatches  = 0;
    int         quiet_count = 0;

    // Predictor state: our own copy of the bound register and of the clusters.
    logic [SAMPLE_W-1:0] bound_copy;
    logic [COUNT_W-1:0]  taken_cnt;
    logic [SAMPLE_W-1:0] anchor   [NUM_CLUST];
    logic                occupied [NUM_CLUST];
    logic [SUM_W-1:0]    acc_sum  [NUM_CLUST];
    logic [VOTES_W-1:0]  tally    [NUM_CLUST];

    t_stim_row stim_rows [NUM_ROWS];

    range_cluster_vote_filter #(
        .P_NUM_READINGS(BURST_LEN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_sample           (i_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_average_distance (o_average_distance),
        .o_winning_votes    (o_winning_votes),
        .o_winning_cluster  (o_winning_cluster)
    );

    always #5 i_clk = ~i_clk;

    // Forget the current burst; the bound register is kept.
    function automatic void clear_clusters();
        taken_cnt = '0;
        for (int k = 0; k < NUM_CLUST; k++) begin
            anchor[k]   = '0;
            occupied[k] = 1'b0;
            acc_sum[k]  = '0;
            tally[k]    = '0;
        end
    endfunction

    // Sort one sample into the clusters. Returns 1 with the result word when
    // the sample closes a burst.
    function automatic bit cluster_sample(input logic [SAMPLE_W-1:0] s,
                                          output t_vote_word w);
        logic [SAMPLE_W:0]  diff;
        logic [CLUST_W-1:0] win;
        logic [31:0]        scaled;
        bit                 placed;
        w      = NO_WORD;
        placed = 1'b0;
        // A zero distance is an invalid reading and leaves everything alone.
        if (s == '0)
            return 1'b0;
        for (int k = 0; k < NUM_CLUST; k++) begin
            if (!placed) begin
                if (!occupied[k]) begin
                    occupied[k] = 1'b1;
                    anchor[k]   = s;
                    acc_sum[k]  = SUM_W'(s);
                    tally[k]    = VOTES_W'(1);
                    placed      = 1'b1;
                end else begin
                    diff = (s >= anchor[k]) ? ({1'b0, s} - {1'b0, anchor[k]})
                                            : ({1'b0, anchor[k]} - {1'b0, s});
                    // The bound is inclusive.
                    if (diff <= {1'b0, bound_copy}) begin
                        acc_sum[k] = acc_sum[k] + SUM_W'(s);
                        tally[k]   = tally[k] + VOTES_W'(1);
                        placed     = 1'b1;
                    end
                end
            end
        end
        // A sample that fits nowhere with all three clusters open still counts.
        taken_cnt = taken_cnt + COUNT_W'(1);
        if (taken_cnt < COUNT_W'(BURST_LEN))
            return 1'b0;
        // Ties go to the higher-numbered cluster.
        if (tally[2] >= tally[1] && tally[2] >= tally[0])
            win = CL_THIRD;
        else if (tally[1] >= tally[0] && tally[1] >= tally[2])
            win = CL_SECOND;
        else
            win = CL_FIRST;
        if (tally[win] != '0)
            scaled = 32'({acc_sum[win], 4'b0000}) / 32'(tally[win]);
        else
            scaled = '0;
        w.avg     = scaled[AVG_W-1:0];
        w.votes   = tally[win];
        w.cluster = win;
        clear_clusters();
        return 1'b1;
    endfunction

    // Monitor: follows every handshake at the clock edge, feeds the predictor,
    // and checks each strobed result word against the oldest owed word.
    always @(posedge i_clk) begin
        t_vote_word got;
        t_vote_word owed;
        bit         took;
        took = 1'b0;
        if (!i_rst_n) begin
            bound_copy = ERROR_BOUND_RST;
            clear_clusters();
            owed_words.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                bound_copy = i_cfg_data;
                took       = 1'b1;
            end
            if (start && !busy) begin
                took = 1'b1;
                if (cluster_sample(i_sample, got))
                    owed_words.push_back(typed_hold ? typed_want : got);
            end
            if (o_strobe === 1'b1) begin
                took = 1'b1;
                if (owed_words.size() == 0) begin
                    $error("result word with none owed: average_distance %0d",
                           o_average_distance);
                    mismatches++;
                end else begin
                    owed = owed_words.pop_front();
                    if (o_average_distance !== owed.avg) begin
                        $error("average_distance: expected %0d, got %0d",
                               owed.avg, o_average_distance);
                        mismatches++;
                    end
                    if (o_winning_votes !== owed.votes) begin
                        $error("winning_votes: expected %0d, got %0d",
                               owed.votes, o_winning_votes);
                        mismatches++;
                    end
                    if (o_winning_cluster !== owed.cluster) begin
                        $error("winning_cluster: expected %0d, got %0d",
                               owed.cluster, o_winning_cluster);
                        mismatches++;
                    end
                end
            end
        end
        quiet_count <= took ? 0 : quiet_count + 1;
    end

    // Watchdog: ends the run when nothing has been taken for too long.
    initial begin
        while (quiet_count < QUIET_LIMIT)
            @(posedge i_clk);
        $display("[range_cluster_vote_filter] ERROR");
        $finish;
    end

    // Send one sample word after a random gap, and return at the edge that
    // takes it. Start is left high so a back-to-back word needs no second
    // assignment in that step.
    task automatic push_word(input logic [SAMPLE_W-1:0] v, input logic typed,
                             input t_vote_word want, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && int'($urandom_range(0, 99)) < idle_pct)
            gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_sample   <= v;
        typed_hold <= typed;
        typed_want <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Wait for every owed word, then long enough for a sample that produced
    // no word to finish its cluster compare.
    task automatic drain_block();
        while (owed_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the error bound once the block is idle.
    task automatic write_bound(input logic [SAMPLE_W-1:0] v);
        start <= 1'b0;
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [SAMPLE_W-1:0] centers [4];
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] bound_pick;
        int                  made;
        int                  phase;
        int                  phase_len;
        int                  idle_pct;
        int                  burst_fill;
        int                  span;
        int                  tgt;
        int                  r;

        // First burst, at the reset bound of 10: a leading and a middle zero,
        // a join at exactly the bound, a miss by one, both sample extremes,
        // a dropped sample once all three clusters are open, and a three-way
        // tie that the third cluster must win.
        stim_rows[0]  = '{ROW_SAMPLE, 16'd0,     1'b0, NO_WORD};
        stim_rows[1]  = '{ROW_SAMPLE, 16'd1,     1'b0, NO_WORD};
        stim_rows[2]  = '{ROW_SAMPLE, 16'd11,    1'b0, NO_WORD};
        stim_rows[3]  = '{ROW_SAMPLE, 16'd12,    1'b0, NO_WORD};
        stim_rows[4]  = '{ROW_SAMPLE, 16'd65535, 1'b0, NO_WORD};
        stim_rows[5]  = '{ROW_SAMPLE, 16'd40000, 1'b0, NO_WORD};
        stim_rows[6]  = '{ROW_SAMPLE, 16'd22,    1'b0, NO_WORD};
        stim_rows[7]  = '{ROW_SAMPLE, 16'd65525, 1'b0, NO_WORD};
        stim_rows[8]  = '{ROW_SAMPLE, 16'd0,     1'b0, NO_WORD};
        stim_rows[9]  = '{ROW_SAMPLE, 16'd65535, 1'b0, NO_WORD};
        stim_rows[10] = '{ROW_SAMPLE, 16'd2,     1'b0, NO_WORD};
        stim_rows[11] = '{ROW_SAMPLE, 16'd21,    1'b0, NO_WORD};
        // Second burst at bound zero: ten full-scale samples all land in the
        // first cluster, giving the largest average the block can report.
        stim_rows[12] = '{ROW_BOUND,  16'd0,     1'b0, NO_WORD};
        for (int k = 13; k < 22; k++)
            stim_rows[k] = '{ROW_SAMPLE, 16'd65535, 1'b0, NO_WORD};
        stim_rows[22] = '{ROW_SAMPLE, 16'd65535, 1'b1,
                          '{20'd1048560, 6'd10, CL_FIRST}};
        stim_rows[23] = '{ROW_BOUND,  16'd65535, 1'b0, NO_WORD};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with no idling.
        for (int k = 0; k < NUM_ROWS; k++) begin
            if (stim_rows[k].kind == ROW_BOUND)
                write_bound(stim_rows[k].value);
            else
                push_word(stim_rows[k].value, stim_rows[k].typed,
                          stim_rows[k].want, 0);
        end

        // Random part. Each phase writes a new bound, then sends samples that
        // mostly sit around a few per-burst centers so clusters actually form,
        // with some zeros and some full-range noise mixed in. A fourth center
        // keeps the all-open drop path busy.
        made       = 0;
        phase      = 0;
        burst_fill = 0;
        for (int k = 0; k < 4; k++)
            centers[k] = SAMPLE_W'($urandom_range(1, 65535));
        while (made < RAND_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       bound_pick = '0;
                1:       bound_pick = '1;
                2, 3:    bound_pick = SAMPLE_W'($urandom_range(1, 40));
                4:       bound_pick = SAMPLE_W'($urandom_range(41, 2000));
                default: bound_pick = SAMPLE_W'($urandom);
            endcase
            write_bound(bound_pick);
            // Phase 0 and 2 run without gaps; the receiver cannot stall, so the
            // receiver-stall phase only sends back to back.
            case (phase % 4)
                1:       idle_pct = 53;
                3:       idle_pct = 33;
                default: idle_pct = 0;
            endcase
            phase_len = $urandom_range(60, 160);
            for (int n = 0; n < phase_len && made < RAND_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    s = '0;
                end else if (r < 12) begin
                    s = SAMPLE_W'($urandom_range(0, 65535));
                end else begin
                    span = int'(bound_pick) + 2;
                    tgt  = int'(centers[$urandom_range(0, 3)])
                         + int'($urandom_range(0, 2 * span)) - span;
                    if (tgt < 1)
                        tgt = 1;
                    if (tgt > 65535)
                        tgt = 65535;
                    s = SAMPLE_W'(tgt);
                end
                push_word(s, 1'b0, NO_WORD, idle_pct);
                made++;
                if (s != '0) begin
                    burst_fill++;
                    // New centers for each burst, sometimes pinned to the ends
                    // of the range.
                    if (burst_fill % BURST_LEN == 0) begin
                        for (int k = 0; k < 4; k++) begin
                            case ($urandom_range(0, 9))
                                0:       centers[k] = SAMPLE_W'(1);
                                1:       centers[k] = '1;
                                default: centers[k] = SAMPLE_W'($urandom_range(1, 65535));
                            endcase
                        end
                    end
                end
            end
            phase++;
        end

        start <= 1'b0;
        drain_block();
        if (owed_words.size() != 0) begin
            $error("result words still owed at the end: %0d", owed_words.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[range_cluster_vote_filter] OK");
        else
            $display("[range_cluster_vote_filter] ERROR");
        $finish;
    end

endmodule
